/* sv/gks_pkg.sv */
// shared types, constants and register map of the gaussian k-space scaler
`timescale 1ns / 1ps
package gks_pkg;

	// fixed-point constants
	localparam logic [63:0] LOG2E_Q30 = 64'd1549082005;
	localparam logic [63:0] LN2_Q31   = 64'd1488522236;
	localparam logic [63:0] LN2_Q32   = 64'd2977044472;
	localparam logic [63:0] ONE_Q32   = 64'h1_0000_0000;

	// default for the exp table depth (power of two)
	localparam int EXP_TABLE_DEPTH_DEF = 256;

	// queue between front and back, and the output queue
	localparam int Q_DEPTH   = 8;
	localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);
	localparam int OQ_DEPTH  = 16;
	localparam int OQ_CNT_W  = $clog2(OQ_DEPTH + 1);

	// payload widths
	localparam int IN_W  = 88;
	localparam int MID_W = 128;
	localparam int OUT_W = 64;

	// register map
	typedef enum logic [2:0] {
		REG_SIZE_X = 3'd0,
		REG_SIZE_Y = 3'd1,
		REG_SIZE_Z = 3'd2,
		REG_STEP_X = 3'd3,
		REG_STEP_Y = 3'd4,
		REG_STEP_Z = 3'd5,
		REG_GAUSS  = 3'd6,
		REG_NORM   = 3'd7
	} reg_idx_t;

	// configuration seen by the datapath
	typedef struct packed {
		logic [8:0]  size_x;
		logic [8:0]  size_y;
		logic [8:0]  size_z;
		logic [31:0] step_x;
		logic [31:0] step_y;
		logic [31:0] step_z;
		logic [31:0] gauss_coef;
		logic [31:0] norm_scale;
	} cfg_t;

endpackage

/* sv/gaussian_kspace_scale.sv */
// top level: register port, front, queues and back of the gaussian k-space scaler
`timescale 1ns / 1ps
// throughput: one item per cycle unless the output side stalls, set by the fully pipelined multiplier chain
// the 8-entry mid queue and 16-entry output queue absorb stalls on either side
// reset: registers return to their reset values and both queues empty
module gaussian_kspace_scale #(
	parameter int EXP_TABLE_DEPTH = gks_pkg::EXP_TABLE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// re_in[31:0], im_in[63:32], idx_x[71:64], idx_y[79:72], idx_z[87:80]
	input  logic [87:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// re_out[31:0], im_out[63:32]
	output logic [63:0] m_axis_tdata
);
	import gks_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t ridx;
	logic     wr_en;

	logic               q_push, q_pop, q_empty;
	logic [MID_W-1:0]   q_in, q_out;
	logic [Q_CNT_W-1:0] q_count;
	logic               oq_push, oq_empty;
	logic [OUT_W-1:0]   oq_in;
	logic [OQ_CNT_W-1:0] oq_count;

	assign ridx   = reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.size_x     <= 9'd64;
			cfg_q.size_y     <= 9'd64;
			cfg_q.size_z     <= 9'd64;
			cfg_q.step_x     <= 32'd65536;
			cfg_q.step_y     <= 32'd65536;
			cfg_q.step_z     <= 32'd65536;
			cfg_q.gauss_coef <= 32'd32768;
			cfg_q.norm_scale <= 32'd16;
		end else if (wr_en) begin
			case (ridx)
				REG_SIZE_X: cfg_q.size_x     <= pwdata[8:0];
				REG_SIZE_Y: cfg_q.size_y     <= pwdata[8:0];
				REG_SIZE_Z: cfg_q.size_z     <= pwdata[8:0];
				REG_STEP_X: cfg_q.step_x     <= pwdata;
				REG_STEP_Y: cfg_q.step_y     <= pwdata;
				REG_STEP_Z: cfg_q.step_z     <= pwdata;
				REG_GAUSS:  cfg_q.gauss_coef <= pwdata;
				REG_NORM:   cfg_q.norm_scale <= pwdata;
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		case (ridx)
			REG_SIZE_X: prdata = {23'd0, cfg_q.size_x};
			REG_SIZE_Y: prdata = {23'd0, cfg_q.size_y};
			REG_SIZE_Z: prdata = {23'd0, cfg_q.size_z};
			REG_STEP_X: prdata = cfg_q.step_x;
			REG_STEP_Y: prdata = cfg_q.step_y;
			REG_STEP_Z: prdata = cfg_q.step_z;
			REG_GAUSS:  prdata = cfg_q.gauss_coef;
			REG_NORM:   prdata = cfg_q.norm_scale;
			default:    prdata = '0;
		endcase
	end

	gks_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (s_axis_tdata),
		.q_count   (q_count),
		.push      (q_push),
		.push_data (q_in)
	);

	gks_fifo #(.WIDTH(MID_W), .DEPTH(Q_DEPTH)) u_mid_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.pop_data  (q_out),
		.empty     (q_empty),
		.count     (q_count)
	);

	gks_back #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_empty  (q_empty),
		.q_data   (q_out),
		.q_pop    (q_pop),
		.oq_count (oq_count),
		.oq_push  (oq_push),
		.oq_data  (oq_in)
	);

	gks_fifo #(.WIDTH(OUT_W), .DEPTH(OQ_DEPTH)) u_out_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (oq_push),
		.push_data (oq_in),
		.pop       (m_axis_tvalid && m_axis_tready),
		.pop_data  (m_axis_tdata),
		.empty     (oq_empty),
		.count     (oq_count)
	);

	assign m_axis_tvalid = !oq_empty;
endmodule

/* sv/gks_fifo.sv */
// small register queue with occupancy count
`timescale 1ns / 1ps
module gks_fifo #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [WIDTH-1:0]             push_data,
	input  logic                         pop,
	output logic [WIDTH-1:0]             pop_data,
	output logic                         empty,
	output logic [$clog2(DEPTH+1)-1:0]   count
);
	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	// pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)  rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
		end
	end

	assign pop_data = mem_q[rd_q];
	assign empty    = (cnt_q == '0);
	assign count    = cnt_q;
endmodule

/* sv/gks_front.sv */
// front: accepts items, folds indices and forms k squared
`timescale 1ns / 1ps
module gks_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  gks_pkg::cfg_t         cfg,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [87:0]           in_data,
	input  logic [gks_pkg::Q_CNT_W-1:0] q_count,
	output logic                  push,
	output logic [127:0]          push_data
);
	import gks_pkg::*;

	logic        v_s1, v_s2, v_s3;
	logic [31:0] re_s1, im_s1, re_s2, im_s2, re_s3, im_s3;
	logic [40:0] ax_s1, ay_s1, az_s1;
	logic [63:0] sx_s2, sy_s2, sz_s2;
	logic        sat_s2;
	logic [63:0] ksq_s3;
	logic        acc;
	logic [64:0] sum_a, sum_b;

	// fold an index to |k|
	function automatic logic [8:0] fold_abs(input logic [7:0] idx, input logic [8:0] size);
		logic [8:0] half;
		logic [8:0] i9;
		half = (size >> 1) + {8'd0, size[0]};
		i9   = {1'b0, idx};
		if (i9 >= half) return (size >= i9) ? size - i9 : i9 - size;
		return i9;
	endfunction

	// credit: items in flight plus queued stay within the queue
	assign in_ready = ({1'b0, q_count} + (Q_CNT_W+1)'(v_s1) + (Q_CNT_W+1)'(v_s2)
		+ (Q_CNT_W+1)'(v_s3)) < (Q_CNT_W+1)'(Q_DEPTH);
	assign acc = in_valid && in_ready;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// saturating sum of the three squares
	always_comb begin
		sum_a = {1'b0, sx_s2} + {1'b0, sy_s2};
		sum_b = {1'b0, sum_a[63:0]} + {1'b0, sz_s2};
	end

	// per-axis step product, squares, sum
	always_ff @(posedge clk) begin
		re_s1 <= in_data[31:0];
		im_s1 <= in_data[63:32];
		ax_s1 <= fold_abs(in_data[71:64], cfg.size_x) * cfg.step_x;
		ay_s1 <= fold_abs(in_data[79:72], cfg.size_y) * cfg.step_y;
		az_s1 <= fold_abs(in_data[87:80], cfg.size_z) * cfg.step_z;

		re_s2  <= re_s1;
		im_s2  <= im_s1;
		sat_s2 <= (ax_s1[40:32] != '0) || (ay_s1[40:32] != '0) || (az_s1[40:32] != '0);
		sx_s2  <= ax_s1[31:0] * ax_s1[31:0];
		sy_s2  <= ay_s1[31:0] * ay_s1[31:0];
		sz_s2  <= az_s1[31:0] * az_s1[31:0];

		re_s3  <= re_s2;
		im_s3  <= im_s2;
		ksq_s3 <= (sat_s2 || sum_a[64] || sum_b[64]) ? '1 : sum_b[63:0];
	end

	assign push      = v_s3;
	assign push_data = {ksq_s3, im_s3, re_s3};
endmodule

/* sv/gks_back.sv */
// back: gaussian factor via exp table and scaling of both parts
`timescale 1ns / 1ps
module gks_back #(
	parameter int EXP_TABLE_DEPTH = gks_pkg::EXP_TABLE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  gks_pkg::cfg_t                cfg,
	input  logic                         q_empty,
	input  logic [127:0]                 q_data,
	output logic                         q_pop,
	input  logic [gks_pkg::OQ_CNT_W-1:0] oq_count,
	output logic                         oq_push,
	output logic [63:0]                  oq_data
);
	import gks_pkg::*;

	localparam int LOG_D  = $clog2(EXP_TABLE_DEPTH);
	localparam int NSTAGE = 12;

	typedef logic [31:0] tab_t [EXP_TABLE_DEPTH];

	// 2^(-i/D) in Q1.31 from a 20-term series
	function automatic tab_t build_tab();
		tab_t        t;
		logic [63:0] arg, term, pos, neg;
		for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
			arg  = (64'(i) * LN2_Q32) / 64'(EXP_TABLE_DEPTH);
			term = ONE_Q32;
			pos  = ONE_Q32;
			neg  = '0;
			for (int k = 1; k <= 20; k++) begin
				term = ((term * arg) >> 32) / 64'(k);
				if ((k % 2) == 1) neg = neg + term;
				else pos = pos + term;
			end
			t[i] = 32'((pos - neg + 64'd1) >> 1);
		end
		return t;
	endfunction

	localparam tab_t POW2_TAB = build_tab();

	logic [NSTAGE-1:0] v_q;
	logic [31:0] re_s [4:13];
	logic [31:0] im_s [4:13];
	logic        zero_s [5:14];
	logic [4:0]  n_s [7:14];

	logic [63:0] phi_s4, plo_s4;
	logic [4:0]  xi_s5;
	logic [31:0] xf_s5;
	logic [4:0]  xi_s6;
	logic [62:0] ym_s6;
	logic [LOG_D-1:0] ti_s7;
	logic [31:0] rem_s7;
	logic [63:0] zp_s8;
	logic [31:0] tab_s8, tab_s9, tab_s10, tab_s11;
	logic [31:0] z_s9, z_s10;
	logic [63:0] zz_s10;
	logic [32:0] c_s11;
	logic [31:0] m_s12;
	logic [33:0] f_s13;
	logic        nre_s14, nim_s14;
	logic [65:0] pre_s14, pim_s14;
	logic [31:0] ore_s15, oim_s15;

	logic [63:0] x_c, y_c;
	logic [31:0] fb_c;
	logic [63:0] rem_full;
	logic [64:0] m_full, f_full;
	logic [32:0] mre_c, mim_c;
	logic [$clog2(NSTAGE+1)-1:0] inflight;

	// scale one part: round half away, saturate to q1.31
	function automatic logic [31:0] finish(input logic [65:0] pr, input logic neg,
		input logic [4:0] n);
		logic [66:0] rnd, r;
		rnd = {1'b0, pr} + (67'd1 << (7'd31 + 7'(n)));
		r   = rnd >> (7'd32 + 7'(n));
		if (neg) begin
			if (r > 67'h8000_0000) r = 67'h8000_0000;
			return 32'(67'd0 - r);
		end
		if (r > 67'h7FFF_FFFF) r = 67'h7FFF_FFFF;
		return r[31:0];
	endfunction

	// credit against the output queue
	assign inflight = ($clog2(NSTAGE+1))'($countones(v_q));
	assign q_pop = !q_empty && ((OQ_CNT_W+1)'(oq_count) + (OQ_CNT_W+1)'(inflight)
		< (OQ_CNT_W+1)'(OQ_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else v_q <= {v_q[NSTAGE-2:0], q_pop};
	end

	// stage helpers
	always_comb begin
		x_c      = (phi_s4 << 16) + (plo_s4 >> 16);
		y_c      = 64'(xi_s6) * LOG2E_Q30 * 64'd4 + 64'(ym_s6 >> 30);
		fb_c     = y_c[31:0];
		rem_full = 64'(fb_c) << LOG_D;
		m_full   = 65'(tab_s11) * 65'(c_s11) + 65'h8000_0000;
		f_full   = 65'(cfg.norm_scale) * 65'(m_s12) + 65'h4000_0000;
		mre_c    = re_s[13][31] ? 33'h1_0000_0000 - {1'b0, re_s[13]} : {1'b0, re_s[13]};
		mim_c    = im_s[13][31] ? 33'h1_0000_0000 - {1'b0, im_s[13]} : {1'b0, im_s[13]};
	end

	// datapath
	always_ff @(posedge clk) begin
		// s4: coefficient times k squared, two halves
		re_s[4] <= q_data[31:0];
		im_s[4] <= q_data[63:32];
		phi_s4  <= q_data[127:96] * cfg.gauss_coef;
		plo_s4  <= q_data[95:64] * cfg.gauss_coef;
		// s5: exponent argument and underflow
		zero_s[5] <= (phi_s4[63:21] != '0) || (x_c[63:37] != '0);
		xi_s5     <= x_c[36:32];
		xf_s5     <= x_c[31:0];
		// s6: fraction times log2(e)
		xi_s6 <= xi_s5;
		ym_s6 <= 63'(xf_s5) * 63'(LOG2E_Q30);
		// s7: split into shift, table index and remainder
		zero_s[7] <= zero_s[6] || (y_c[63:37] != '0);
		n_s[7]    <= y_c[36:32];
		ti_s7     <= fb_c[31 -: LOG_D];
		rem_s7    <= rem_full[31:0];
		// s8: remainder times ln2, table read
		zp_s8  <= 64'(rem_s7) * LN2_Q31;
		tab_s8 <= POW2_TAB[ti_s7];
		// s9: correction argument
		z_s9   <= 32'((zp_s8 >> 31) >> LOG_D);
		tab_s9 <= tab_s8;
		// s10: square of the argument
		zz_s10  <= z_s9 * z_s9;
		z_s10   <= z_s9;
		tab_s10 <= tab_s9;
		// s11: second-order correction
		c_s11   <= 33'(ONE_Q32 - 64'(z_s10) + (zz_s10 >> 33));
		tab_s11 <= tab_s10;
		// s12: corrected power of two
		m_s12 <= m_full[63:32];
		// s13: norm scale
		f_s13 <= f_full[64:31];
		// s14: magnitudes times factor
		nre_s14 <= re_s[13][31];
		nim_s14 <= im_s[13][31];
		pre_s14 <= 66'(mre_c) * 66'(f_s13);
		pim_s14 <= 66'(mim_c) * 66'(f_s13);
		// s15: round, shift, saturate
		ore_s15 <= zero_s[14] ? '0 : finish(pre_s14, nre_s14, n_s[14]);
		oim_s15 <= zero_s[14] ? '0 : finish(pim_s14, nim_s14, n_s[14]);

		// side-band delay lines
		for (int s = 5; s <= 13; s++) begin
			re_s[s] <= re_s[s-1];
			im_s[s] <= im_s[s-1];
		end
		zero_s[6] <= zero_s[5];
		for (int s = 8; s <= 14; s++) begin
			zero_s[s] <= zero_s[s-1];
			n_s[s]    <= n_s[s-1];
		end
	end

	assign oq_push = v_q[NSTAGE-1];
	assign oq_data = {oim_s15, ore_s15};
endmodule

/* test/testbench.sv */
// self-checking testbench of the gaussian k-space scaler
`timescale 1ns / 1ps
module testbench;
	import gks_pkg::*;

	localparam int TABLE_D = 256;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	// re_in[31:0], im_in[63:32], idx_x[71:64], idx_y[79:72], idx_z[87:80]
	logic [87:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// re_out[31:0], im_out[63:32]
	logic [63:0] m_axis_tdata;

	gaussian_kspace_scale i_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #5 clk = ~clk;

	// scaler model: own copy of the registers and the 2^(-i/D) table
	cfg_t        model_cfg;
	logic [31:0] pow2_rom [TABLE_D];
	logic [63:0] scaled_q[$];
	int          n_errors = 0;
	bit          idle_on = 1'b1;
	int          rx_hold = 0;
	int          rx_stall = 0;

	// exp(-t) for t below one, Q.32 in and out
	function automatic logic [63:0] exp_neg_series(input logic [63:0] t);
		logic [63:0] term, pos, neg;
		term = ONE_Q32;
		pos = ONE_Q32;
		neg = 0;
		for (int k = 1; k <= 20; k++) begin
			term = ((term * t) >> 32) / k;
			if (k % 2 == 1) neg += term;
			else pos += term;
		end
		return pos - neg;
	endfunction

	function automatic logic [63:0] folded_mag(input logic [63:0] idx, input logic [63:0] sz);
		logic [63:0] half;
		half = (sz >> 1) + (sz & 1);
		if (idx >= half) return (sz >= idx) ? sz - idx : idx - sz;
		return idx;
	endfunction

	function automatic logic [31:0] scale_part(input logic [31:0] raw, input logic [63:0] f,
			input int s);
		logic [63:0] mag, r;
		mag = raw[31] ? ONE_Q32 - {32'd0, raw} : {32'd0, raw};
		r = (mag * f + (64'd1 << (s - 1))) >> s;
		if (raw[31]) begin
			if (r > 64'd2147483648) r = 64'd2147483648;
			r = ONE_Q32 - r;
			return r[31:0];
		end
		if (r > 64'd2147483647) r = 64'd2147483647;
		return r[31:0];
	endfunction

	// expected {im_out, re_out} for one coefficient under the model registers
	function automatic logic [63:0] gaussian_scaled(input logic [87:0] d);
		logic [63:0] idx [3], sz [3], st [3];
		logic [63:0] ksq, a, sq, x, y, f, hi, lo, fd, i, rem, z, c, m;
		logic [63:0] coef, nrm;
		bit          sat, zero;
		int          n;
		idx[0] = d[71:64]; idx[1] = d[79:72]; idx[2] = d[87:80];
		sz[0] = model_cfg.size_x; sz[1] = model_cfg.size_y; sz[2] = model_cfg.size_z;
		st[0] = model_cfg.step_x; st[1] = model_cfg.step_y; st[2] = model_cfg.step_z;
		coef = model_cfg.gauss_coef;
		nrm = model_cfg.norm_scale;
		sat = 0; zero = 0; ksq = 0; x = 0; f = 0; n = 0;
		for (int ax = 0; ax < 3; ax++) begin
			a = folded_mag(idx[ax], sz[ax]) * st[ax];
			if (a > 64'hFFFF_FFFF) begin
				sat = 1;
				sq = 0;
			end else sq = a * a;
			ksq = (ksq > ~sq) ? '1 : ksq + sq;
		end
		if (sat) ksq = '1;
		// gaussian argument, underflow when it reaches 32
		if (coef != 0) begin
			hi = ksq >> 32;
			lo = ksq & 64'hFFFF_FFFF;
			if (hi * coef >= (64'd1 << 21)) zero = 1;
			else begin
				x = ((hi * coef) << 16) + ((lo * coef) >> 16);
				if (x >= (64'd32 << 32)) zero = 1;
			end
		end
		if (!zero) begin
			y = (x >> 32) * LOG2E_Q30 * 4 + (((x & 64'hFFFF_FFFF) * LOG2E_Q30) >> 30);
			if ((y >> 32) >= 32) zero = 1;
			else begin
				fd = (y & 64'hFFFF_FFFF) * TABLE_D;
				i = fd >> 32;
				rem = fd & 64'hFFFF_FFFF;
				if (i >= TABLE_D) i = TABLE_D - 1;
				z = ((rem * LN2_Q31) >> 31) / TABLE_D;
				c = ONE_Q32 - z + (((z * z) >> 32) >> 1);
				m = ({32'd0, pow2_rom[i]} * c + (64'd1 << 31)) >> 32;
				f = (nrm * m + (64'd1 << 30)) >> 31;
				n = int'(y >> 32);
			end
		end
		if (zero) return 64'd0;
		return {scale_part(d[63:32], f, 32 + n), scale_part(d[31:0], f, 32 + n)};
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		n_errors++;
	endtask

	// result checker
	always @(posedge clk) begin
		logic [63:0] want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (scaled_q.size() == 0) report_mismatch("unexpected item", m_axis_tdata[31:0], 0);
			else begin
				want = scaled_q.pop_front();
				if (m_axis_tdata[31:0] !== want[31:0])
					report_mismatch("re_out", m_axis_tdata[31:0], want[31:0]);
				if (m_axis_tdata[63:32] !== want[63:32])
					report_mismatch("im_out", m_axis_tdata[63:32], want[63:32]);
			end
		end
	end

	// receiver: long hold, random stall bursts or ready
	initial begin
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				m_axis_tready <= 1'b0;
				rx_hold--;
			end else if (rx_stall > 0) begin
				m_axis_tready <= 1'b0;
				rx_stall--;
			end else if (idle_on && arst_n && $urandom_range(0, 7) == 0) begin
				m_axis_tready <= 1'b0;
				rx_stall = $urandom_range(0, 9);
			end else m_axis_tready <= arst_n;
		end
	end

	// send one item, with an optional random gap first
	task automatic send_coeff(input logic [87:0] d);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(0, 9)) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= d;
		do @(posedge clk); while (!s_axis_tready);
		scaled_q.push_back(gaussian_scaled(d));
	endtask

	task automatic release_bus();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
	endtask

	task automatic wait_drained();
		release_bus();
		while (scaled_q.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic apb_write(input reg_idx_t r, input logic [31:0] v);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= {r, 2'b00}; pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0;
		case (r)
			REG_SIZE_X: model_cfg.size_x = v[8:0];
			REG_SIZE_Y: model_cfg.size_y = v[8:0];
			REG_SIZE_Z: model_cfg.size_z = v[8:0];
			REG_STEP_X: model_cfg.step_x = v;
			REG_STEP_Y: model_cfg.step_y = v;
			REG_STEP_Z: model_cfg.step_z = v;
			REG_GAUSS:  model_cfg.gauss_coef = v;
			REG_NORM:   model_cfg.norm_scale = v;
			default: ;
		endcase
	endtask

	task automatic apb_check(input reg_idx_t r, input logic [31:0] want);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b0; penable <= 1'b0; paddr <= {r, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want) report_mismatch(r.name(), prdata, want);
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0;
	endtask

	task automatic set_all(input logic [31:0] sx, sy, sz, tx, ty, tz, g, nr);
		apb_write(REG_SIZE_X, sx); apb_write(REG_SIZE_Y, sy); apb_write(REG_SIZE_Z, sz);
		apb_write(REG_STEP_X, tx); apb_write(REG_STEP_Y, ty); apb_write(REG_STEP_Z, tz);
		apb_write(REG_GAUSS, g); apb_write(REG_NORM, nr);
	endtask

	function automatic logic [31:0] rand_part();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [87:0] rand_coeff();
		logic [7:0] ix, iy, iz;
		ix = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8));
		iy = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8));
		iz = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8));
		return {iz, iy, ix, rand_part(), rand_part()};
	endfunction

	function automatic logic [31:0] rand_scale();
		return $urandom_range(0, 32'd1 << $urandom_range(4, 20));
	endfunction

	// reset values of size_x, step_y, gauss and norm, then every register written and read back
	task automatic test_registers();
		apb_check(REG_SIZE_X, 64); apb_check(REG_STEP_Y, 65536);
		apb_check(REG_GAUSS, 32768); apb_check(REG_NORM, 16);
		set_all(256, 2, 255, 32'hFFFF_FFFF, 0, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		apb_check(REG_SIZE_X, 256); apb_check(REG_SIZE_Y, 2); apb_check(REG_SIZE_Z, 255);
		apb_check(REG_STEP_X, 32'hFFFF_FFFF); apb_check(REG_STEP_Y, 0);
		apb_check(REG_STEP_Z, 1); apb_check(REG_GAUSS, 32'hFFFF_FFFF);
		apb_check(REG_NORM, 32'hFFFF_FFFF);
	endtask

	// extremes of the fields, zero coefficient, underflow and folding
	task automatic test_directed();
		set_all(64, 64, 64, 65536, 65536, 65536, 32768, 16);
		send_coeff({8'd0, 8'd0, 8'd0, 32'h7FFF_FFFF, 32'h8000_0000});
		send_coeff({8'd1, 8'd2, 8'd3, 32'h8000_0000, 32'h7FFF_FFFF});
		send_coeff({8'd32, 8'd33, 8'd63, 32'hFFFF_FFFF, 32'h0000_0001});
		send_coeff({8'd255, 8'd255, 8'd128, 32'h1234_5678, 32'h9ABC_DEF0});
		wait_drained();
		// no attenuation, full norm: saturation of the output
		set_all(2, 256, 255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF);
		send_coeff({8'd0, 8'd0, 8'd0, 32'h7FFF_FFFF, 32'h8000_0000});
		send_coeff({8'd255, 8'd200, 8'd1, 32'h8000_0000, 32'h7FFF_FFFF});
		send_coeff({8'd127, 8'd128, 8'd255, 32'hFFFF_FFFF, 32'h4000_0000});
		wait_drained();
		// underflow: saturated k squared with a live coefficient, plus the zero index
		apb_write(REG_GAUSS, 32'hFFFF_FFFF);
		send_coeff({8'd0, 8'd0, 8'd0, 32'h7FFF_FFFF, 32'h8000_0000});
		send_coeff({8'd1, 8'd1, 8'd1, 32'h7FFF_FFFF, 32'h8000_0000});
		send_coeff({8'd5, 8'd0, 8'd0, 32'h0123_4567, 32'hFEDC_BA98});
		wait_drained();
		// small steps near the underflow edge
		set_all(3, 5, 7, 3000, 20000, 65536, 65536, 32'h8000_0000);
		for (int k = 0; k < 8; k++) send_coeff({8'(k), 8'(k), 8'(k), rand_part(), rand_part()});
		wait_drained();
	endtask

	task automatic test_random_phase(input int n_items);
		set_all($urandom_range(2, 256), $urandom_range(2, 256), $urandom_range(2, 256),
			rand_scale(), rand_scale(), rand_scale(),
			($urandom_range(0, 4) == 0) ? $urandom : rand_scale(), $urandom);
		for (int k = 0; k < n_items; k++) send_coeff(rand_coeff());
		wait_drained();
	endtask

	// receiver holds off long enough for both queues to fill
	task automatic test_backpressure();
		set_all(16, 16, 16, 4096, 4096, 4096, 1024, 32'hFFFF_FFFF);
		rx_hold = 300;
		for (int k = 0; k < 80; k++) send_coeff(rand_coeff());
		// sender pause until every result is back, then more
		wait_drained();
		for (int k = 0; k < 40; k++) send_coeff(rand_coeff());
		wait_drained();
	endtask

	initial begin
		for (int i = 0; i < TABLE_D; i++) begin
			logic [63:0] e;
			e = exp_neg_series((64'(i) * LN2_Q32) / TABLE_D);
			pow2_rom[i] = 32'((e + 1) >> 1);
		end
		model_cfg = '{size_x: 64, size_y: 64, size_z: 64, step_x: 65536, step_y: 65536,
			step_z: 65536, gauss_coef: 32768, norm_scale: 16};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (4) @(posedge clk);
		test_registers();
		test_directed();
		for (int p = 0; p < 5; p++) test_random_phase(200);
		test_backpressure();
		idle_on = 1'b0;
		test_random_phase(150);
		test_random_phase(30);
		repeat (40) @(posedge clk);
		if (scaled_q.size() != 0) begin
			$display("%0d items never came out", scaled_q.size());
			n_errors++;
		end
		if (n_errors == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end

	// watchdog
	initial begin
		#5ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule

/* files.f */
sv/gks_pkg.sv
sv/gks_fifo.sv
sv/gks_front.sv
sv/gks_back.sv
sv/gaussian_kspace_scale.sv
test/testbench.sv
